// ===== rtl/core/imrt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// imrt_pkg: shared types and constants
// constants, status codes and controller/datapath command types
// ----------------------------------------------------------------------------
package imrt_pkg;
  localparam int Capacity  = 32;
  localparam int KeyBits   = 32;
  localparam int ValueBits = 8;
  localparam int IdxBits   = $clog2(Capacity);
  localparam int CntBits   = $clog2(Capacity + 1);

  typedef logic [KeyBits-1:0]   key_t;
  typedef logic [ValueBits-1:0] value_t;
  typedef logic [IdxBits-1:0]   idx_t;
  typedef logic [CntBits-1:0]   cnt_t;

  localparam logic [1:0] StatusDone  = 2'd0;
  localparam logic [1:0] StatusEmpty = 2'd1;
  localparam logic [1:0] StatusFull  = 2'd2;

  localparam logic OpAssign = 1'b0;
  localparam logic OpLookup = 1'b1;

  // command from controller to datapath
  typedef struct packed {
    logic load;       // capture input item
    logic scan;       // evaluate entry at scan index
    logic scan_rd;    // issue read at scan index
    logic copy_init;  // set tail copy pointers
    logic copy_rd;    // issue read at copy source
    logic copy_wr;    // write staged entry to table
    logic wr_begin;   // write begin breakpoint
    logic wr_end;     // write end breakpoint
    logic commit;     // update entry count
    logic out_load;   // build result
  } cmd_t;

  typedef struct packed {
    logic scan_last;  // scan index reached count
    logic copy_last;  // copy source has passed its last entry
    logic is_lookup;
    logic empty_int;
    logic full;
    logic ins_b;
    logic ins_e;
    logic shift_up;   // tail moves to higher index
    logic no_move;    // tail stays put or there is no tail
  } stat_t;
endpackage
`default_nettype wire

// ===== rtl/core/imrt_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// imrt_if: valid/ready channel interfaces
// input item, result item and configuration write channels
// ----------------------------------------------------------------------------
interface imrt_in_if;
  logic                  valid;
  logic                  ready;
  logic                  operation;
  imrt_pkg::key_t        range_begin;
  imrt_pkg::key_t        range_end;
  imrt_pkg::value_t      new_value;
  imrt_pkg::key_t        query_key;
  modport source (output valid, operation, range_begin, range_end, new_value, query_key,
                  input ready);
  modport sink (input valid, operation, range_begin, range_end, new_value, query_key,
                output ready);
endinterface

interface imrt_out_if;
  logic                  valid;
  logic                  ready;
  imrt_pkg::value_t      looked_up_value;
  logic [1:0]            status;
  logic [5:0]            entries_used;
  modport source (output valid, looked_up_value, status, entries_used, input ready);
  modport sink (input valid, looked_up_value, status, entries_used, output ready);
endinterface

interface imrt_cfg_if;
  logic                  valid;
  logic                  ready;
  imrt_pkg::value_t      data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/imrt_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// imrt_ram: generic single-port-write, single-read ram
// registered read data
// ----------------------------------------------------------------------------
module imrt_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/core/imrt_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// imrt_datapath: breakpoint table and scan/shift datapath
// holds key/value rams, entry count and the per-item working registers
// ----------------------------------------------------------------------------
module imrt_datapath (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire imrt_pkg::cmd_t   cmd,
  output imrt_pkg::stat_t       stat,
  input  wire logic             in_op,
  input  wire imrt_pkg::key_t   in_begin,
  input  wire imrt_pkg::key_t   in_end,
  input  wire imrt_pkg::value_t in_value,
  input  wire imrt_pkg::key_t   in_query,
  input  wire imrt_pkg::value_t default_value,
  output imrt_pkg::value_t      res_value,
  output logic [1:0]            res_status,
  output logic [5:0]            res_count
);
  localparam int Cap = imrt_pkg::Capacity;

  logic op;
  imrt_pkg::key_t kb, ke, kq;   // sign-flipped keys
  imrt_pkg::value_t v;
  imrt_pkg::cnt_t count;
  imrt_pkg::cnt_t scan_i, n_lo, hi;
  imrt_pkg::value_t before_v, end_v, q_v;
  imrt_pkg::cnt_t src, dst;
  imrt_pkg::cnt_t new_count;

  imrt_pkg::cnt_t raddr_c;
  imrt_pkg::key_t rkey;
  imrt_pkg::value_t rval;
  logic we;
  imrt_pkg::cnt_t waddr_c;
  imrt_pkg::key_t wkey;
  imrt_pkg::value_t wval;
  logic [imrt_pkg::CntBits+1:0] total;
  imrt_pkg::key_t rk;
  logic ins_b, ins_e;

  always_comb begin
    raddr_c = scan_i;
    if (cmd.copy_rd) begin
      raddr_c = src;
    end
  end

  imrt_ram #(.Width(imrt_pkg::KeyBits), .Depth(Cap)) u_keys (
    .clk(clk), .we(we), .waddr(waddr_c[imrt_pkg::IdxBits-1:0]), .wdata(wkey),
    .raddr(raddr_c[imrt_pkg::IdxBits-1:0]), .rdata(rkey));
  imrt_ram #(.Width(imrt_pkg::ValueBits), .Depth(Cap)) u_vals (
    .clk(clk), .we(we), .waddr(waddr_c[imrt_pkg::IdxBits-1:0]), .wdata(wval),
    .raddr(raddr_c[imrt_pkg::IdxBits-1:0]), .rdata(rval));

  assign rk = rkey;
  assign ins_b = (before_v != v);
  assign ins_e = (end_v != v);
  assign total = {2'b0, n_lo} + {{(imrt_pkg::CntBits+1){1'b0}}, ins_b}
               + {{(imrt_pkg::CntBits+1){1'b0}}, ins_e} + {2'b0, count} - {2'b0, hi};
  assign new_count = n_lo + imrt_pkg::cnt_t'(ins_b) + imrt_pkg::cnt_t'(ins_e)
                   + count - hi;

  // writes: begin/end breakpoints or tail copy
  always_comb begin
    we = 1'b0;
    waddr_c = dst;
    wkey = rkey;
    wval = rval;
    if (cmd.wr_begin) begin
      we = 1'b1;
      waddr_c = n_lo;
      wkey = kb ^ {1'b1, {(imrt_pkg::KeyBits-1){1'b0}}};
      wval = v;
    end else if (cmd.wr_end) begin
      we = 1'b1;
      waddr_c = n_lo + imrt_pkg::cnt_t'(ins_b);
      wkey = ke ^ {1'b1, {(imrt_pkg::KeyBits-1){1'b0}}};
      wval = end_v;
    end else if (cmd.copy_wr) begin
      we = 1'b1;
    end
  end

  assign stat.scan_last = (scan_i == count);
  // upward copy runs from the top entry down to entry hi inclusive
  assign stat.copy_last = stat.shift_up ? (src == imrt_pkg::cnt_t'(hi - 1'b1))
                                        : (src == count);
  assign stat.is_lookup = (op == imrt_pkg::OpLookup);
  assign stat.empty_int = (kb >= ke);
  assign stat.full = (total > (imrt_pkg::CntBits+2)'(Cap));
  assign stat.ins_b = ins_b;
  assign stat.ins_e = ins_e;
  assign stat.shift_up = (new_count > count);
  assign stat.no_move = (new_count == count) || (hi == count);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.commit) begin
      count <= new_count;
    end
    if (cmd.load) begin
      op <= in_op;
      kb <= in_begin ^ {1'b1, {(imrt_pkg::KeyBits-1){1'b0}}};
      ke <= in_end ^ {1'b1, {(imrt_pkg::KeyBits-1){1'b0}}};
      kq <= in_query ^ {1'b1, {(imrt_pkg::KeyBits-1){1'b0}}};
      v <= in_value;
      scan_i <= '0;
      n_lo <= '0;
      hi <= '0;
      before_v <= default_value;
      end_v <= default_value;
      q_v <= default_value;
    end
    if (cmd.scan_rd) begin
      scan_i <= scan_i + 1'b1;
    end
    // rkey/rval hold entry scan_i-1 during scan
    if (cmd.scan) begin
      if ((rk ^ {1'b1, {(imrt_pkg::KeyBits-1){1'b0}}}) < kb) begin
        n_lo <= n_lo + 1'b1;
        before_v <= rval;
      end
      if ((rk ^ {1'b1, {(imrt_pkg::KeyBits-1){1'b0}}}) <= ke) begin
        hi <= hi + 1'b1;
        end_v <= rval;
      end
      if ((rk ^ {1'b1, {(imrt_pkg::KeyBits-1){1'b0}}}) <= kq) begin
        q_v <= rval;
      end
    end
    if (cmd.copy_init) begin
      // prepare tail copy pointers
      if (new_count > count) begin
        src <= count - 1'b1;
        dst <= new_count - 1'b1;
      end else begin
        src <= hi;
        dst <= new_count - (count - hi);
      end
    end
    if (cmd.copy_wr) begin
      if (stat.shift_up) begin
        src <= src - 1'b1;
        dst <= dst - 1'b1;
      end else begin
        src <= src + 1'b1;
        dst <= dst + 1'b1;
      end
    end
    if (cmd.out_load) begin
      res_value <= '0;
      res_status <= imrt_pkg::StatusDone;
      if (op == imrt_pkg::OpLookup) begin
        res_value <= q_v;
      end else if (kb >= ke) begin
        res_status <= imrt_pkg::StatusEmpty;
      end else if (stat.full) begin
        res_status <= imrt_pkg::StatusFull;
      end
    end
  end

  assign res_count = 6'(count);
endmodule
`default_nettype wire

// ===== rtl/core/imrt_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// imrt_ctrl: item sequencer
// scans the table, then for an accepted assign shifts the tail and writes the new breakpoints
// ----------------------------------------------------------------------------
module imrt_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  output imrt_pkg::cmd_t      cmd,
  input  wire imrt_pkg::stat_t stat
);
  typedef enum logic [2:0] {
    Idle, ScanRd, Scan, Decide, CopyRd, CopyWr, WrBeg, WrEnd
  } state_t;

  state_t state, state_next;
  logic out_pend;
  logic out_set;

  assign in_ready = (state == Idle) && !out_pend;
  assign out_valid = out_pend;

  // tail shift precedes breakpoint writes; shift_up copies from top down
  // entry count is updated only once the table has been rebuilt
  always_comb begin
    cmd = '0;
    state_next = state;
    out_set = 1'b0;
    case (state)
      Idle: begin
        if (in_valid && in_ready) begin
          cmd.load = 1'b1;
          state_next = ScanRd;
        end
      end
      ScanRd: begin
        if (stat.scan_last) begin
          state_next = Decide;
        end else begin
          cmd.scan_rd = 1'b1;
          state_next = Scan;
        end
      end
      Scan: begin
        cmd.scan = 1'b1;
        state_next = ScanRd;
      end
      Decide: begin
        cmd.out_load = 1'b1;
        if (stat.is_lookup || stat.empty_int || stat.full) begin
          out_set = 1'b1;
          state_next = Idle;
        end else begin
          cmd.copy_init = 1'b1;
          state_next = stat.no_move ? WrBeg : CopyRd;
        end
      end
      CopyRd: begin
        if (stat.copy_last) begin
          state_next = WrBeg;
        end else begin
          cmd.copy_rd = 1'b1;
          state_next = CopyWr;
        end
      end
      CopyWr: begin
        cmd.copy_wr = 1'b1;
        state_next = CopyRd;
      end
      WrBeg: begin
        cmd.wr_begin = stat.ins_b;
        state_next = WrEnd;
      end
      WrEnd: begin
        cmd.wr_end = stat.ins_e;
        cmd.commit = 1'b1;
        out_set = 1'b1;
        state_next = Idle;
      end
      default: state_next = Idle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= Idle;
      out_pend <= 1'b0;
    end else begin
      state <= state_next;
      if (out_set) begin
        out_pend <= 1'b1;
      end else if (out_ready) begin
        out_pend <= 1'b0;
      end
    end
  end

`ifndef SYNTH
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != Idle) |-> !in_ready) else $error("accept while busy");
  a_load_from_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == ScanRd)) else $error("load did not start scan");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_pend && !out_ready) |=> out_pend) else $error("result dropped");
`endif
endmodule
`default_nettype wire

// ===== rtl/core/interval_map_range_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// interval_map_range_table: piecewise-constant key-to-value map
// sorted breakpoint table with assign-interval and lookup operations
// ----------------------------------------------------------------------------
// usage:
//   in_ch  : one transaction per item (assign or lookup)
//   out_ch : one transaction per item with value, status and entry count
//   cfg_ch : writes default_value; only while the block is idle
// sequence:
//   a lookup scans all N entries held: the scan reads each ram entry in turn
//   through the single read port, alternating the ScanRd and Scan states
//   an assign adds up to N tail shifting steps (CopyRd, CopyWr) plus the
//   breakpoint write states WrBeg and WrEnd
// one item is in flight at a time; the next input transaction is taken
// once the result has been delivered
// reset clears the entry count and the default; table rams are not cleared
// a stalled receiver holds the result and the input side waits
// ----------------------------------------------------------------------------
module interval_map_range_table (
  input wire logic  clk,
  input wire logic  rst,
  imrt_in_if.sink   in_ch,
  imrt_out_if.source out_ch,
  imrt_cfg_if.sink  cfg_ch
);
  imrt_pkg::cmd_t   cmd;
  imrt_pkg::stat_t  stat;
  imrt_pkg::value_t default_value;

  // configuration register
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      default_value <= '0;
    end else if (cfg_ch.valid) begin
      default_value <= cfg_ch.data;
    end
  end

  imrt_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cmd(cmd), .stat(stat)
  );

  imrt_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .in_op(in_ch.operation), .in_begin(in_ch.range_begin), .in_end(in_ch.range_end),
    .in_value(in_ch.new_value), .in_query(in_ch.query_key),
    .default_value(default_value),
    .res_value(out_ch.looked_up_value), .res_status(out_ch.status),
    .res_count(out_ch.entries_used)
  );
endmodule
`default_nettype wire

// ===== verif/interval_map_range_table_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_map_range_table_test: self-checking bench for the breakpoint map
// drives assign and lookup items, predicts each result with a behavioral
// copy of the table and compares every result field in order
// ----------------------------------------------------------------------------
module interval_map_range_table_test;
  logic clk = 1'b0;
  logic rst = 1'b1;

  imrt_in_if  in_ch();
  imrt_out_if out_ch();
  imrt_cfg_if cfg_ch();

  interval_map_range_table DUT (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ending guard: 1859 items, with a time limit many times over their worst case
  initial begin
    #60000000;
    $display("Simulation FAILED");
    $finish;
  end

  // result record and the queue of expected results
  typedef struct packed {
    imrt_pkg::value_t value;
    logic [1:0]       status;
    logic [5:0]       used;
  } map_result_t;

  map_result_t pending_results[$];
  int          error_count = 0;

  // model of the table; keys held as signed ints
  int               model_keys[imrt_pkg::Capacity];
  imrt_pkg::value_t model_vals[imrt_pkg::Capacity];
  int               model_count = 0;
  imrt_pkg::value_t model_default = '0;

  // receiver control
  bit hold_off = 1'b0;

  function automatic imrt_pkg::value_t value_in_force(int k);
    int n = 0;
    while (n < model_count && model_keys[n] <= k) n++;
    return (n == 0) ? model_default : model_vals[n - 1];
  endfunction

  function automatic map_result_t apply_item(logic op, int b, int e,
                                             imrt_pkg::value_t v, int q);
    map_result_t      r;
    int               n_lo, hi, total, w;
    imrt_pkg::value_t before_v, end_v;
    bit               ins_b, ins_e;
    int               nk[imrt_pkg::Capacity];
    imrt_pkg::value_t nv[imrt_pkg::Capacity];
    r.value = '0;
    r.status = imrt_pkg::StatusDone;
    if (op == imrt_pkg::OpLookup) begin
      r.value = value_in_force(q);
    end else if (b >= e) begin
      r.status = imrt_pkg::StatusEmpty;
    end else begin
      n_lo = 0;
      while (n_lo < model_count && model_keys[n_lo] < b) n_lo++;
      hi = 0;
      while (hi < model_count && model_keys[hi] <= e) hi++;
      before_v = (n_lo == 0) ? model_default : model_vals[n_lo - 1];
      end_v = value_in_force(e);
      ins_b = before_v != v;
      ins_e = end_v != v;
      total = n_lo + ins_b + ins_e + (model_count - hi);
      if (total > imrt_pkg::Capacity) begin
        r.status = imrt_pkg::StatusFull;
      end else begin
        w = 0;
        for (int i = 0; i < n_lo; i++) begin
          nk[w] = model_keys[i]; nv[w] = model_vals[i]; w++;
        end
        if (ins_b) begin
          nk[w] = b; nv[w] = v; w++;
        end
        if (ins_e) begin
          nk[w] = e; nv[w] = end_v; w++;
        end
        for (int i = hi; i < model_count; i++) begin
          nk[w] = model_keys[i]; nv[w] = model_vals[i]; w++;
        end
        model_keys = nk;
        model_vals = nv;
        model_count = w;
      end
    end
    r.used = 6'(model_count);
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // receiver: random wait per result plus one long hold-off window
  initial begin
    int wait_n;
    out_ch.ready = 1'b0;
    forever begin
      wait_n = $urandom_range(0, 13);
      if (wait_n > 0 || hold_off) begin
        out_ch.ready <= 1'b0;
        repeat (wait_n) @(posedge clk);
        while (hold_off) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // result checker
  always @(posedge clk) begin
    map_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result transaction", 1, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.looked_up_value !== want.value)
          report_mismatch("looked_up_value", out_ch.looked_up_value, want.value);
        if (out_ch.status !== want.status)
          report_mismatch("status", out_ch.status, want.status);
        if (out_ch.entries_used !== want.used)
          report_mismatch("entries_used", out_ch.entries_used, want.used);
      end
    end
  end

  // one input transaction, with a random gap first
  task automatic send_item(logic op, int b, int e, imrt_pkg::value_t v, int q);
    int gap = $urandom_range(0, 13);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.operation   <= op;
    in_ch.range_begin <= b;
    in_ch.range_end   <= e;
    in_ch.new_value   <= v;
    in_ch.query_key   <= q;
    pending_results.push_back(apply_item(op, b, e, v, q));
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // drop valid after the last accepted transaction
  task automatic stop_input();
    in_ch.valid <= 1'b0;
  endtask

  // default write only while idle
  task automatic write_default(imrt_pkg::value_t v);
    stop_input();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    model_default = v;
  endtask

  // random key: mostly a narrow window so intervals overlap, sometimes anything or an extreme
  function automatic int pick_key();
    case ($urandom_range(0, 9))
      0:       return int'($urandom());
      1:       return ($urandom_range(0, 1) != 0) ? 32'sh7fffffff : 32'sh80000000;
      default: return int'($urandom_range(0, 80)) - 40;
    endcase
  endfunction

  typedef struct {
    logic             op;
    int               b;
    int               e;
    imrt_pkg::value_t v;
    int               q;
    bit               typed;   // expected result given in the row
    map_result_t      r;
  } stim_row_t;

  stim_row_t directed[] = '{
    // fresh table: lookup returns default, empty count
    '{imrt_pkg::OpLookup, 0, 0, 8'h00, 0, 1, '{8'h00, imrt_pkg::StatusDone, 6'd0}},
    // empty interval
    '{imrt_pkg::OpAssign, 5, 5, 8'h11, 0, 1, '{8'h00, imrt_pkg::StatusEmpty, 6'd0}},
    '{imrt_pkg::OpAssign, 9, -3, 8'h11, 0, 1, '{8'h00, imrt_pkg::StatusEmpty, 6'd0}},
    // assigning the default changes nothing
    '{imrt_pkg::OpAssign, -10, 10, 8'h00, 0, 1, '{8'h00, imrt_pkg::StatusDone, 6'd0}},
    // extreme keys
    '{imrt_pkg::OpAssign, 32'sh80000000, 32'sh7fffffff, 8'hff, 0, 1,
      '{8'h00, imrt_pkg::StatusDone, 6'd2}},
    '{imrt_pkg::OpLookup, 0, 0, 8'h00, 32'sh80000000, 1,
      '{8'hff, imrt_pkg::StatusDone, 6'd2}},
    '{imrt_pkg::OpLookup, 0, 0, 8'h00, 32'sh7fffffff, 1,
      '{8'h00, imrt_pkg::StatusDone, 6'd2}},
    '{imrt_pkg::OpLookup, 0, 0, 8'h00, 32'sh7ffffffe, 1,
      '{8'hff, imrt_pkg::StatusDone, 6'd2}},
    // split, merge and erase
    '{imrt_pkg::OpAssign, -5, 5, 8'h22, 0, 0, '{8'h00, imrt_pkg::StatusDone, 6'd0}},
    '{imrt_pkg::OpAssign, 5, 8, 8'h22, 0, 0, '{8'h00, imrt_pkg::StatusDone, 6'd0}},
    '{imrt_pkg::OpAssign, -5, 8, 8'hff, 0, 0, '{8'h00, imrt_pkg::StatusDone, 6'd0}},
    '{imrt_pkg::OpLookup, 5, 9, 8'h55, 0, 0, '{8'h00, imrt_pkg::StatusDone, 6'd0}},
    '{imrt_pkg::OpAssign, 32'sh80000000, 32'sh7fffffff, 8'h00, -1, 1,
      '{8'h00, imrt_pkg::StatusDone, 6'd0}},
    '{imrt_pkg::OpAssign, 1, 2, 8'haa, 0, 0, '{8'h00, imrt_pkg::StatusDone, 6'd0}},
    '{imrt_pkg::OpAssign, 2, 3, 8'h55, 0, 0, '{8'h00, imrt_pkg::StatusDone, 6'd0}},
    '{imrt_pkg::OpLookup, 0, 0, 8'h00, 2, 0, '{8'h00, imrt_pkg::StatusDone, 6'd0}}
  };

  initial begin
    map_result_t got;
    int b, e, k;
    in_ch.valid = 1'b0;
    in_ch.operation = imrt_pkg::OpAssign;
    in_ch.range_begin = '0;
    in_ch.range_end = '0;
    in_ch.new_value = '0;
    in_ch.query_key = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows; typed expectations double as predictor sanity
    foreach (directed[i]) begin
      send_item(directed[i].op, directed[i].b, directed[i].e, directed[i].v, directed[i].q);
      got = pending_results[$];
      if (directed[i].typed && got != directed[i].r)
        report_mismatch("directed row prediction", i, -1);
    end

    // fill the table with single-key steps until it is refused
    for (int i = 0; i < 36; i++)
      send_item(imrt_pkg::OpAssign, 100 + 2 * i, 101 + 2 * i,
                imrt_pkg::value_t'(i + 1), 0);

    // long receiver hold-off while items keep coming
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 4; i++)
        send_item(imrt_pkg::OpLookup, 0, 0, 8'h00, 100 + 2 * i);
    join

    // random phases, each with its own default
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_default(8'hff);
        1: write_default(8'h00);
        default: write_default(imrt_pkg::value_t'($urandom_range(0, 255)));
      endcase
      // clear the table now and then
      if (phase % 2 == 0) send_item(imrt_pkg::OpAssign, 32'sh80000000, 32'sh7fffffff,
                                    model_default, 0);
      for (int i = 0; i < 300; i++) begin
        if ($urandom_range(0, 2) == 0) begin
          k = pick_key();
          send_item(imrt_pkg::OpLookup, int'($urandom()), int'($urandom()),
                    imrt_pkg::value_t'($urandom()), k);
        end else begin
          b = pick_key();
          e = ($urandom_range(0, 7) == 0) ? pick_key() : b + int'($urandom_range(1, 12));
          if ($urandom_range(0, 9) == 0) e = b;
          send_item(imrt_pkg::OpAssign, b, e,
                    ($urandom_range(0, 3) == 0) ? model_default
                                                : imrt_pkg::value_t'($urandom_range(0, 255)),
                    int'($urandom()));
        end
      end
    end

    stop_input();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
